FILE: rtl/mmu_pkg.sv
package mmu_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_FRAC_BITS = 16;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int IDX_IN_W  = 3;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B  = 2'd2;

endpackage

FILE: rtl/matrix_multiply_unit.sv
// dense matrix product c = a x b, signed fixed point with FRAC_BITS fraction bits
// input channel (valid/ready): command 0 writes one element of a, command 1 one
//   element of b, at row/col; loads outside the configured sizes and command 3
//   are dropped. command 2 computes the whole product
// result channel (valid/ready): one beat per element of c in row-major order,
//   out_last set on the final one; values floor-shifted and saturated to 32 bits
// config port: write-only, index 0 rows of a, 1 inner size, 2 columns of b;
//   0 acts as 1, values above MAX_DIM act as MAX_DIM; write only while idle
// timing: a four-entry queue sits between the accepting front and the compute
//   back. loads retire one per cycle while the back is idle, so in_ready stays
//   high on a load stream then. each result element passes through the single
//   multiply-accumulate pipe reading one a and one b word per cycle from the
//   operand memories (read, multiply, accumulate, saturate)
// stall: a waiting result holds in the output register; the back waits there
//   while the front keeps filling the queue until it is full
// reset: config returns to 8/8/8, queue and pipe empty; operand stores keep
//   their contents and are undefined until written
module matrix_multiply_unit #(
  parameter int MAX_DIM   = mmu_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = mmu_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mmu_pkg::CMD_W-1:0]        in_command,
  input  logic [mmu_pkg::IDX_IN_W-1:0]     in_row_index,
  input  logic [mmu_pkg::IDX_IN_W-1:0]     in_col_index,
  input  logic signed [mmu_pkg::VAL_W-1:0] in_element_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mmu_pkg::IDX_IN_W-1:0]     out_row,
  output logic [mmu_pkg::IDX_IN_W-1:0]     out_col,
  output logic signed [mmu_pkg::VAL_W-1:0] out_value,
  output logic                             out_last,
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmu_pkg::DIM_W-1:0]        cfg_data
);

  localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DIM_CNT_W = $clog2(MAX_DIM + 1);
  // queue word: kind, store address, element value
  localparam int QW        = mmu_pkg::KIND_W + ADDR_W + mmu_pkg::VAL_W;

  logic                 q_push;
  logic [QW-1:0]        q_push_data;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_ready;
  logic [QW-1:0]        q_data;
  logic [DIM_CNT_W-1:0] dim_rows;
  logic [DIM_CNT_W-1:0] dim_inner;
  logic [DIM_CNT_W-1:0] dim_cols;

  // front: config registers, bounds check, store address
  mmu_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_push_data),
    .dim_rows         (dim_rows),
    .dim_inner        (dim_inner),
    .dim_cols         (dim_cols)
  );

  // decoupling queue
  mmu_fifo #(
    .W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  // back: operand stores, multiply-accumulate, result register
  mmu_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .dim_rows  (dim_rows),
    .dim_inner (dim_inner),
    .dim_cols  (dim_cols),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/mmu_fifo.sv
module mmu_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (mmu_pkg::Q_DEPTH > 1) ? $clog2(mmu_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(mmu_pkg::Q_DEPTH + 1);

  logic [W-1:0]     slot_r [mmu_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign full      = (cnt_r == CNT_W'(mmu_pkg::Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == mmu_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == mmu_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/mmu_front.sv
module mmu_front #(
  parameter int MAX_DIM = mmu_pkg::DEF_MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mmu_pkg::CMD_W-1:0]           in_command,
  input  logic [mmu_pkg::IDX_IN_W-1:0]        in_row_index,
  input  logic [mmu_pkg::IDX_IN_W-1:0]        in_col_index,
  input  logic signed [mmu_pkg::VAL_W-1:0]    in_element_value,
  input  logic                                cfg_wr_en,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmu_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [mmu_pkg::KIND_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)
                + mmu_pkg::VAL_W - 1:0]       q_data,
  output logic [$clog2(MAX_DIM + 1)-1:0]      dim_rows,
  output logic [$clog2(MAX_DIM + 1)-1:0]      dim_inner,
  output logic [$clog2(MAX_DIM + 1)-1:0]      dim_cols
);

  localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DIM_CNT_W = $clog2(MAX_DIM + 1);

  logic [mmu_pkg::DIM_W-1:0] rows_r;
  logic [mmu_pkg::DIM_W-1:0] inner_r;
  logic [mmu_pkg::DIM_W-1:0] cols_r;
  logic                      keep;
  mmu_pkg::kind_t            kind;
  logic [ADDR_W-1:0]         addr;

  // zero acts as one, anything above the store size as the store size
  function automatic logic [DIM_CNT_W-1:0] clamp_dim(input logic [mmu_pkg::DIM_W-1:0] v);
    if (v == '0) return DIM_CNT_W'(1);
    if (int'(v) > MAX_DIM) return DIM_CNT_W'(MAX_DIM);
    return DIM_CNT_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mmu_pkg::DIM_RESET;
      inner_r <= mmu_pkg::DIM_RESET;
      cols_r  <= mmu_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mmu_pkg::REG_ROWS_OF_A:  rows_r  <= cfg_data;
        mmu_pkg::REG_INNER_SIZE: inner_r <= cfg_data;
        mmu_pkg::REG_COLS_OF_B:  cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dim_rows  = clamp_dim(rows_r);
  assign dim_inner = clamp_dim(inner_r);
  assign dim_cols  = clamp_dim(cols_r);

  // classify: out-of-bound loads and unused codes are dropped here
  always_comb begin
    keep = 1'b0;
    kind = mmu_pkg::KIND_COMPUTE;
    addr = ADDR_W'(int'(in_row_index) * MAX_DIM + int'(in_col_index));
    unique case (mmu_pkg::cmd_t'(in_command))
      mmu_pkg::CMD_LOAD_A: begin
        kind = mmu_pkg::KIND_LOAD_A;
        keep = (int'(in_row_index) < int'(dim_rows)) && (int'(in_col_index) < int'(dim_inner));
      end
      mmu_pkg::CMD_LOAD_B: begin
        kind = mmu_pkg::KIND_LOAD_B;
        keep = (int'(in_row_index) < int'(dim_inner)) && (int'(in_col_index) < int'(dim_cols));
      end
      mmu_pkg::CMD_COMPUTE: begin
        kind = mmu_pkg::KIND_COMPUTE;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;
  assign q_data   = {kind, addr, in_element_value};

endmodule

FILE: rtl/mmu_back.sv
module mmu_back #(
  parameter int MAX_DIM   = mmu_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = mmu_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  logic [mmu_pkg::KIND_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)
                + mmu_pkg::VAL_W - 1:0]    q_data,
  input  logic [$clog2(MAX_DIM + 1)-1:0]   dim_rows,
  input  logic [$clog2(MAX_DIM + 1)-1:0]   dim_inner,
  input  logic [$clog2(MAX_DIM + 1)-1:0]   dim_cols,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mmu_pkg::IDX_IN_W-1:0]     out_row,
  output logic [mmu_pkg::IDX_IN_W-1:0]     out_col,
  output logic signed [mmu_pkg::VAL_W-1:0] out_value,
  output logic                             out_last
);

  localparam int VAL_W     = mmu_pkg::VAL_W;
  localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DIM_CNT_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int QW        = mmu_pkg::KIND_W + ADDR_W + VAL_W;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);
  localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_HOLD} state_t;

  state_t                   state_r;
  logic [IDX_W-1:0]         i_r;
  logic [IDX_W-1:0]         j_r;
  logic [IDX_W-1:0]         t_r;
  logic                     out_valid_r;
  logic [mmu_pkg::IDX_IN_W-1:0] out_row_r;
  logic [mmu_pkg::IDX_IN_W-1:0] out_col_r;
  logic [VAL_W-1:0]         out_value_r;
  logic                     out_last_r;

  logic [VAL_W-1:0]         a_mem [DEPTH];
  logic [VAL_W-1:0]         b_mem [DEPTH];
  logic [VAL_W-1:0]         a_rd_r;
  logic [VAL_W-1:0]         b_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     s1_vld_r, s1_first_r, s1_last_r;
  logic                     s2_vld_r, s2_first_r, s2_last_r;
  logic                     acc_done_r;

  mmu_pkg::kind_t           kind;
  logic [ADDR_W-1:0]        q_addr;
  logic [VAL_W-1:0]         q_val;
  logic                     pop;
  logic                     issue;
  logic [ADDR_W-1:0]        a_rd_addr;
  logic [ADDR_W-1:0]        b_rd_addr;
  logic                     t_last, j_last, i_last;
  logic signed [ACC_W-1:0]  acc_shift;
  logic                     fits;
  logic [VAL_W-1:0]         sat_value;

  assign kind   = mmu_pkg::kind_t'(q_data[QW-1 -: mmu_pkg::KIND_W]);
  assign q_addr = q_data[VAL_W +: ADDR_W];
  assign q_val  = q_data[VAL_W-1:0];

  assign q_ready = (state_r == ST_IDLE);
  assign pop     = q_valid && q_ready;
  assign issue   = (state_r == ST_RUN);

  assign a_rd_addr = ADDR_W'(int'(i_r) * MAX_DIM + int'(t_r));
  assign b_rd_addr = ADDR_W'(int'(t_r) * MAX_DIM + int'(j_r));

  assign t_last = (DIM_CNT_W'(t_r) + DIM_CNT_W'(1)) == dim_inner;
  assign j_last = (DIM_CNT_W'(j_r) + DIM_CNT_W'(1)) == dim_cols;
  assign i_last = (DIM_CNT_W'(i_r) + DIM_CNT_W'(1)) == dim_rows;

  // operand stores
  always_ff @(posedge clk) begin
    if (pop && kind == mmu_pkg::KIND_LOAD_A) begin
      a_mem[q_addr] <= q_val;
    end
    if (pop && kind == mmu_pkg::KIND_LOAD_B) begin
      b_mem[q_addr] <= q_val;
    end
    a_rd_r <= a_mem[a_rd_addr];
    b_rd_r <= b_mem[b_rd_addr];
  end

  // multiply and accumulate datapath
  always_ff @(posedge clk) begin
    prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
    if (s2_vld_r) begin
      acc_r <= s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_vld_r   <= 1'b0;
      s2_first_r <= 1'b0;
      s2_last_r  <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      s1_vld_r   <= issue;
      s1_first_r <= (t_r == '0);
      s1_last_r  <= t_last;
      s2_vld_r   <= s1_vld_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      acc_done_r <= s2_vld_r && s2_last_r;
    end
  end

  // floor shift to the output scale, then saturate
  assign acc_shift = acc_r >>> FRAC_BITS;
  assign fits      = (&acc_shift[ACC_W-1:VAL_W-1]) || !(|acc_shift[ACC_W-1:VAL_W-1]);
  assign sat_value = fits ? acc_shift[VAL_W-1:0] : (acc_shift[ACC_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      t_r         <= '0;
    end else begin
      if (acc_done_r) begin
        out_valid_r <= 1'b1;
        out_value_r <= sat_value;
        out_row_r   <= mmu_pkg::IDX_IN_W'(i_r);
        out_col_r   <= mmu_pkg::IDX_IN_W'(j_r);
        out_last_r  <= i_last && j_last;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop && kind == mmu_pkg::KIND_COMPUTE) begin
            i_r     <= '0;
            j_r     <= '0;
            t_r     <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (t_last) begin
            t_r     <= '0;
            state_r <= ST_DRAIN;
          end else begin
            t_r <= t_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (acc_done_r) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_valid_r && out_ready) begin
            if (j_last) begin
              j_r <= '0;
              if (i_last) begin
                state_r <= ST_IDLE;
              end else begin
                i_r     <= i_r + IDX_W'(1);
                state_r <= ST_RUN;
              end
            end else begin
              j_r     <= j_r + IDX_W'(1);
              state_r <= ST_RUN;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

FILE: verif/tb_matrix_multiply_unit.sv
`timescale 1ns / 100ps

module tb_matrix_multiply_unit;

  localparam int DIM      = mmu_pkg::DEF_MAX_DIM;
  localparam int FRAC     = mmu_pkg::DEF_FRAC_BITS;
  localparam int IDX_W    = mmu_pkg::IDX_IN_W;
  localparam int DIM_BITS = mmu_pkg::DIM_W;
  // command code that the block has to drop
  localparam logic [mmu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  // loads can sit in the front queue after the last result beat
  localparam int SETTLE_CYCLES = 24;
  localparam int RUN_LIMIT_NS  = 5000000;

  typedef struct {
    logic [mmu_pkg::IDX_IN_W-1:0]     row;
    logic [mmu_pkg::IDX_IN_W-1:0]     col;
    logic signed [mmu_pkg::VAL_W-1:0] value;
    logic                             last;
  } c_elem_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [mmu_pkg::CMD_W-1:0]        in_command = '0;
  logic [mmu_pkg::IDX_IN_W-1:0]     in_row_index = '0;
  logic [mmu_pkg::IDX_IN_W-1:0]     in_col_index = '0;
  logic signed [mmu_pkg::VAL_W-1:0] in_element_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [mmu_pkg::IDX_IN_W-1:0]     out_row;
  logic [mmu_pkg::IDX_IN_W-1:0]     out_col;
  logic signed [mmu_pkg::VAL_W-1:0] out_value;
  logic                             out_last;
  logic                             cfg_wr_en = 1'b0;
  logic [mmu_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [mmu_pkg::DIM_W-1:0]        cfg_data = '0;

  // throttling, in percent of cycles
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int err_count = 0;
  // input beats sent, dropped ones included
  int sent_items = 0;
  int round_no = 0;

  // mirror of the operand stores and the size registers
  logic signed [mmu_pkg::VAL_W-1:0] a_mat [DIM][DIM];
  logic signed [mmu_pkg::VAL_W-1:0] b_mat [DIM][DIM];
  bit                               a_set [DIM][DIM];
  bit                               b_set [DIM][DIM];
  logic [mmu_pkg::DIM_W-1:0]        reg_rows  = mmu_pkg::DIM_RESET;
  logic [mmu_pkg::DIM_W-1:0]        reg_inner = mmu_pkg::DIM_RESET;
  logic [mmu_pkg::DIM_W-1:0]        reg_cols  = mmu_pkg::DIM_RESET;

  // elements of c still owed by the block, oldest first
  c_elem_t c_elems_due [$];

  matrix_multiply_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // zero acts as one, anything past the array size acts as the array size
  function automatic int clamp_dim(input logic [mmu_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > DIM) return DIM;
    return int'(v);
  endfunction

  // exact sum of q32.32 products, floor shift back to q16.16, then clip to 32 bits
  function automatic logic signed [mmu_pkg::VAL_W-1:0] dot_product(input int i,
                                                                   input int j,
                                                                   input int nk);
    logic signed [71:0] acc;
    logic signed [63:0] term;
    logic signed [71:0] shifted;
    acc = '0;
    for (int t = 0; t < nk; t++) begin
      term = 64'(a_mat[i][t]) * 64'(b_mat[t][j]);
      acc  = acc + 72'(term);
    end
    shifted = acc >>> FRAC;
    if (shifted > 72'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (shifted < -72'sh80000000) return 32'sh80000000;
    return shifted[mmu_pkg::VAL_W-1:0];
  endfunction

  // state update for one accepted beat; a compute queues the whole of c
  function automatic void load_or_multiply(input logic [mmu_pkg::CMD_W-1:0] cmd,
                                           input logic [mmu_pkg::IDX_IN_W-1:0] row,
                                           input logic [mmu_pkg::IDX_IN_W-1:0] col,
                                           input logic signed [mmu_pkg::VAL_W-1:0] val);
    int      nr;
    int      nk;
    int      nc;
    c_elem_t e;
    nr = clamp_dim(reg_rows);
    nk = clamp_dim(reg_inner);
    nc = clamp_dim(reg_cols);
    case (cmd)
      mmu_pkg::CMD_LOAD_A: begin
        if (int'(row) < nr && int'(col) < nk) begin
          a_mat[row][col] = val;
          a_set[row][col] = 1'b1;
        end
      end
      mmu_pkg::CMD_LOAD_B: begin
        if (int'(row) < nk && int'(col) < nc) begin
          b_mat[row][col] = val;
          b_set[row][col] = 1'b1;
        end
      end
      mmu_pkg::CMD_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            e.row   = IDX_W'(i);
            e.col   = IDX_W'(j);
            e.value = dot_product(i, j, nk);
            e.last  = (i == nr - 1) && (j == nc - 1);
            c_elems_due.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // one input beat; valid stays up after acceptance so back-to-back beats
  // never drop it within a time step
  task automatic send_item(input logic [mmu_pkg::CMD_W-1:0] cmd,
                           input logic [mmu_pkg::IDX_IN_W-1:0] row,
                           input logic [mmu_pkg::IDX_IN_W-1:0] col,
                           input logic signed [mmu_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_row_index     <= row;
    in_col_index     <= col;
    in_element_value <= val;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    load_or_multiply(cmd, row, col, val);
  endtask

  // drain: all of c delivered, then let queued loads retire
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (c_elems_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // call only while idle; enable stays high across the three writes
  task automatic set_dims(input logic [mmu_pkg::DIM_W-1:0] r,
                          input logic [mmu_pkg::DIM_W-1:0] k,
                          input logic [mmu_pkg::DIM_W-1:0] c);
    cfg_wr_en <= 1'b1;
    cfg_index <= mmu_pkg::REG_ROWS_OF_A;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= mmu_pkg::REG_INNER_SIZE;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= mmu_pkg::REG_COLS_OF_B;
    cfg_data  <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_rows  = r;
    reg_inner = k;
    reg_cols  = c;
  endtask

  // full-range values mixed with small ones so that not every sum clips
  function automatic logic signed [mmu_pkg::VAL_W-1:0] rand_value();
    logic signed [mmu_pkg::VAL_W-1:0] v;
    v = $urandom;
    if ($urandom_range(3) != 0) v = v >>> $urandom_range(10, 24);
    return v;
  endfunction

  function automatic logic [mmu_pkg::DIM_W-1:0] rand_dim();
    int p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return 4'd15;
    if (p < 22) return 4'd8;
    if (p < 28) return DIM_BITS'($urandom_range(9, 14));
    return DIM_BITS'($urandom_range(1, 4));
  endfunction

  task automatic send_wellformed_load();
    int nr;
    int nk;
    int nc;
    nr = clamp_dim(reg_rows);
    nk = clamp_dim(reg_inner);
    nc = clamp_dim(reg_cols);
    if ($urandom_range(1))
      send_item(mmu_pkg::CMD_LOAD_A, IDX_W'($urandom_range(nr - 1)),
                IDX_W'($urandom_range(nk - 1)), rand_value());
    else
      send_item(mmu_pkg::CMD_LOAD_B, IDX_W'($urandom_range(nk - 1)),
                IDX_W'($urandom_range(nc - 1)), rand_value());
  endtask

  // mostly proper loads, some stray indices and the unused command
  task automatic send_mixed();
    int p;
    p = $urandom_range(99);
    if (p < 70)
      send_wellformed_load();
    else if (p < 85)
      send_item($urandom_range(1) ? mmu_pkg::CMD_LOAD_A : mmu_pkg::CMD_LOAD_B,
                IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)), rand_value());
    else
      send_item(CMD_UNUSED, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                $urandom);
  endtask

  // every operand the next compute reads must have been written
  task automatic fill_operands();
    int nr;
    int nk;
    int nc;
    nr = clamp_dim(reg_rows);
    nk = clamp_dim(reg_inner);
    nc = clamp_dim(reg_cols);
    for (int i = 0; i < nr; i++)
      for (int t = 0; t < nk; t++)
        if (!a_set[i][t]) send_item(mmu_pkg::CMD_LOAD_A, IDX_W'(i), IDX_W'(t), rand_value());
    for (int t = 0; t < nk; t++)
      for (int j = 0; j < nc; j++)
        if (!b_set[t][j]) send_item(mmu_pkg::CMD_LOAD_B, IDX_W'(t), IDX_W'(j), rand_value());
  endtask

  // sizes of zero act as one
  task automatic test_clamped_minimum();
    wait_idle();
    set_dims(4'd0, 4'd0, 4'd0);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'sh00010000);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'shFFFD8000);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd7, 3'd7, 32'shFFFFFFFF);
  endtask

  // loads outside the sizes and the unused command must not touch the stores
  task automatic test_dropped_loads();
    wait_idle();
    set_dims(4'd1, 4'd2, 4'd1);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'sh00018000);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd1, 32'shFFFFC000);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'sh00020000);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd1, 3'd0, 32'sh00040000);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
    wait_idle();
    set_dims(4'd1, 4'd1, 4'd1);
    // these alias the live entries once the inner size grows back
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd1, 32'sh7FFFFFFF);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd1, 3'd0, 32'sh80000000);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd7, 3'd7, 32'sh7FFFFFFF);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd7, 3'd7, 32'sh7FFFFFFF);
    send_item(CMD_UNUSED, 3'd7, 3'd7, 32'shFFFFFFFF);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
    wait_idle();
    set_dims(4'd1, 4'd2, 4'd1);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
  endtask

  // sums beyond 32 bits, both signs, including one past 64 bits
  task automatic test_saturation();
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'sh7FFFFFFF);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd1, 32'sh7FFFFFFF);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'sh7FFFFFFF);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd1, 3'd0, 32'sh7FFFFFFF);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'sh80000000);
    send_item(mmu_pkg::CMD_LOAD_B, 3'd1, 3'd0, 32'sh80000000);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'sh80000000);
    send_item(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd1, 32'sh80000000);
    send_item(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
  endtask

  // one size setting: loads with noise, operand fill, product, trailing loads
  task automatic run_round();
    logic [mmu_pkg::DIM_W-1:0] r;
    logic [mmu_pkg::DIM_W-1:0] k;
    logic [mmu_pkg::DIM_W-1:0] c;
    if (round_no == 0) begin
      // widest result, 64 beats
      r = 4'd15;
      k = 4'd1;
      c = 4'd15;
    end else if (round_no == 1) begin
      // longest dot product
      r = 4'd1;
      k = 4'd15;
      c = 4'd1;
    end else begin
      r = rand_dim();
      k = rand_dim();
      c = rand_dim();
    end
    round_no++;
    wait_idle();
    set_dims(r, k, c);
    repeat ($urandom_range(1, 8)) send_mixed();
    fill_operands();
    send_item(mmu_pkg::CMD_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
              $urandom);
    // a second product right behind the first keeps the queue busy
    if ($urandom_range(4) == 0)
      send_item(mmu_pkg::CMD_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                $urandom);
    repeat ($urandom_range(0, 3)) send_wellformed_load();
  endtask

  task automatic test_random(input int n_items);
    int start;
    start = sent_items;
    while (sent_items - start < n_items) run_round();
  endtask

  // compare each delivered element against the oldest one owed
  always @(posedge clk) begin : result_check
    c_elem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (c_elems_due.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed: r%0d c%0d %h last %b",
                                  out_row, out_col, out_value, out_last));
      end else begin
        want = c_elems_due.pop_front();
        if (out_row !== want.row || out_col !== want.col ||
            out_value !== want.value || out_last !== want.last)
          report_mismatch($sformatf("got r%0d c%0d %h last %b, want r%0d c%0d %h last %b",
                                    out_row, out_col, out_value, out_last,
                                    want.row, want.col, want.value, want.last));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow sender, stalling receiver
    snd_idle_pct = 29;
    rcv_idle_pct = 64;
    test_clamped_minimum();
    test_dropped_loads();
    test_saturation();
    test_random(100);

    // bursty receiver, gappy sender
    snd_idle_pct = 64;
    rcv_idle_pct = 29;
    test_random(100);

    // full throughput
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(100);

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
